>>> rtl/core/assert_macros.svh
// Assertion macros for the deframer RTL; included by wsd_parser.
// Each macro uses the enclosing module's clk and rst_n; empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge out of reset.
`define WSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("deframer assertion failed");
// Antecedent at one edge implies consequent at the next.
`define WSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define WSD_ASSERT(lbl, prop)
`define WSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/wsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the WebSocket deframer.
// No dependencies; used by wsd_parser and websocket_frame_deframer.
package wsd_pkg;

  localparam int unsigned MAXLEN_W = 24;
  localparam int unsigned LEN_W    = 64;

  localparam logic [MAXLEN_W-1:0] MAX_PAYLOAD_RST = 24'd65536;

  // frame opcodes
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // 7-bit length escapes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_PING  = 2'd2;
  localparam logic [1:0] KIND_DROP  = 2'd3;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } wsd_res_t;

endpackage

>>> rtl/core/wsd_parser.sv
`timescale 1ns / 1ps
// Frame parser state and per-byte next-state logic.
// Depends on wsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsd_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_i,
  input  logic [7:0]                     byte_i,
  input  logic [wsd_pkg::MAXLEN_W-1:0]   max_payload_i,
  output wsd_pkg::wsd_res_t              res_o
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_PAYLOAD
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [3:0]       opcode_r, opcode_nxt;
  logic             mask_on_r, mask_on_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [2:0]       ext_cnt_r, ext_cnt_nxt;
  logic [31:0]      mask_key_r, mask_key_nxt;
  logic [1:0]       key_idx_r, key_idx_nxt;
  logic             closed_r, closed_nxt;

  wsd_res_t         res;
  logic             len_done;
  logic [LEN_W-1:0] rem_dec;
  logic [4:0]       key_sh;
  logic [7:0]       key_byte;
  logic             oversize;

  // key byte 0 lives in bits 31:24
  assign key_sh   = {~key_idx_r, 3'b000};
  assign key_byte = 8'(mask_key_r >> key_sh);
  assign rem_dec  = rem_r - LEN_W'(1);

  // result is formed for the byte at hand; state only moves when step_i is high
  always_comb begin
    phase_nxt    = phase_r;
    opcode_nxt   = opcode_r;
    mask_on_nxt  = mask_on_r;
    rem_nxt      = rem_r;
    ext_cnt_nxt  = ext_cnt_r;
    mask_key_nxt = mask_key_r;
    key_idx_nxt  = key_idx_r;
    closed_nxt   = closed_r;
    res          = '0;
    len_done     = 1'b0;

    if (!closed_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          opcode_nxt = byte_i[3:0];
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_on_nxt  = byte_i[7];
          mask_key_nxt = '0;
          key_idx_nxt  = '0;
          if (opcode_r == OP_CLOSE) begin
            closed_nxt = 1'b1;
            phase_nxt  = PH_HDR0;
            res.vld    = 1'b1;
            res.kind   = KIND_CLOSE;
          end else if (byte_i[6:0] == LEN_EXT16) begin
            rem_nxt     = '0;
            ext_cnt_nxt = 3'd1;
            phase_nxt   = PH_EXT;
          end else if (byte_i[6:0] == LEN_EXT64) begin
            rem_nxt     = '0;
            ext_cnt_nxt = 3'd7;
            phase_nxt   = PH_EXT;
          end else begin
            rem_nxt  = {{(LEN_W-7){1'b0}}, byte_i[6:0]};
            len_done = 1'b1;
          end
        end
        PH_EXT: begin
          rem_nxt = {rem_r[LEN_W-9:0], byte_i};
          if (ext_cnt_r == 3'd0) begin
            len_done = 1'b1;
          end else begin
            ext_cnt_nxt = ext_cnt_r - 3'd1;
          end
        end
        PH_MASK: begin
          mask_key_nxt = mask_key_r | ({24'b0, byte_i} << key_sh);
          if (key_idx_r == 2'd3) begin
            key_idx_nxt = '0;
            phase_nxt   = (rem_r != '0) ? PH_PAYLOAD : PH_HDR0;
          end else begin
            key_idx_nxt = key_idx_r + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          key_idx_nxt = key_idx_r + 2'd1;
          rem_nxt     = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = PH_HDR0;
          end
          if (opcode_r == OP_TEXT) begin
            res.vld  = 1'b1;
            res.kind = KIND_DATA;
            res.data = byte_i ^ key_byte;
            res.last = (rem_dec == '0);
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase
    end

    oversize = (|rem_nxt[LEN_W-1:MAXLEN_W]) ||
               (rem_nxt[MAXLEN_W-1:0] > max_payload_i);

    // length complete: decide the frame's fate
    if (len_done) begin
      priority if (opcode_r == OP_PING) begin
        res.vld  = 1'b1;
        res.kind = KIND_PING;
      end else if (opcode_r != OP_TEXT) begin
        res.vld  = 1'b1;
        res.kind = KIND_DROP;
      end else if (oversize) begin
        opcode_nxt = '0;
        res.vld    = 1'b1;
        res.kind   = KIND_DROP;
      end
      if (mask_on_nxt) begin
        key_idx_nxt = '0;
        phase_nxt   = PH_MASK;
      end else begin
        phase_nxt = (rem_nxt != '0) ? PH_PAYLOAD : PH_HDR0;
      end
    end
  end

  assign res_o    = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      opcode_r   <= '0;
      mask_on_r  <= 1'b0;
      rem_r      <= '0;
      ext_cnt_r  <= '0;
      mask_key_r <= '0;
      key_idx_r  <= '0;
      closed_r   <= 1'b0;
    end else if (step_i) begin
      phase_r    <= phase_nxt;
      opcode_r   <= opcode_nxt;
      mask_on_r  <= mask_on_nxt;
      rem_r      <= rem_nxt;
      ext_cnt_r  <= ext_cnt_nxt;
      mask_key_r <= mask_key_nxt;
      key_idx_r  <= key_idx_nxt;
      closed_r   <= closed_nxt;
    end
  end

  `WSD_ASSERT(a_closed_silent, !(closed_r && res.vld))
  `WSD_ASSERT_NEXT(a_closed_sticky, closed_r, closed_r)
  `WSD_ASSERT(a_payload_has_len, !(phase_r == PH_PAYLOAD && rem_r == '0))
  `WSD_ASSERT_NEXT(a_last_ends_frame, step_i && res.vld && res.last, phase_r == PH_HDR0)

endmodule

>>> rtl/core/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// WebSocket (RFC 6455) receive deframer. Takes one connection byte per request on
// the in_ channel and returns at most one event per byte on the out_ channel:
// unmasked text payload bytes (kind 0, last marks the final byte), close seen
// (kind 1, all later bytes ignored until reset), ping seen (kind 2) or frame
// dropped (kind 3, payload skipped). Throughput is one byte per clock while
// in_stall is low; each byte passes an input register, combinational parser logic
// whose critical path is the 64-bit length decrement and compare, and an output
// register that holds its event until out_stall is low at a clock edge. in_stall
// rises only while a byte that makes an event meets a full, stalled output
// register. cfg_max_payload must be written only while idle; the block does not
// enforce it. cfg_ready is always high. Depends on wsd_pkg and wsd_parser.
module websocket_frame_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_data,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsd_pkg::MAXLEN_W-1:0]  cfg_max_payload
);
  import wsd_pkg::*;

  logic [MAXLEN_W-1:0] max_payload_r;
  logic                in_full_r;
  logic [7:0]          in_byte_r;
  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic [7:0]          out_data_r;
  logic                out_last_r;

  wsd_res_t            res;
  logic                adv;
  logic                in_take;

  // byte in the input register moves on unless it makes an event with nowhere to go
  assign adv     = in_full_r && (!res.vld || !out_valid_r || !out_stall);
  assign in_stall = in_full_r && !adv;
  assign in_take = in_valid && !in_stall;

  wsd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_i        (adv),
    .byte_i        (in_byte_r),
    .max_payload_i (max_payload_r),
    .res_o         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
      in_full_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_payload_r <= cfg_max_payload;
      end
      if (in_take) begin
        in_full_r <= 1'b1;
      end else if (adv) begin
        in_full_r <= 1'b0;
      end
      if (adv && res.vld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv && res.vld) begin
      out_kind_r <= res.kind;
      out_data_r <= res.data;
      out_last_r <= res.last;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

>>> tb/websocket_frame_deframer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_deframer: byte-level frame stimulus,
// an in-bench parser that predicts every event, and a scoreboard on the out_ channel.
// Depends on wsd_pkg and the deframer RTL.
module websocket_frame_deframer_test;
  import wsd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 250;

  // continuation opcode, used in stimulus and by the shadow parser
  localparam logic [3:0] OP_CONT = 4'h0;

  typedef enum logic [2:0] {P_HDR0, P_HDR1, P_EXT, P_KEY, P_BODY} parse_phase_t;
  typedef enum int {FORM_7, FORM_16, FORM_64} len_form_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pattern_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } frame_event_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_rx_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_kind;
  logic [7:0]          out_data;
  logic                out_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [MAXLEN_W-1:0] cfg_max_payload = '0;

  websocket_frame_deframer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data        (out_data),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_payload (cfg_max_payload)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser shadow state
  parse_phase_t        m_phase = P_HDR0;
  logic [3:0]          m_opcode = '0;
  logic                m_mask_on = 1'b0;
  logic [LEN_W-1:0]    m_remaining = '0;
  logic [2:0]          m_ext_left = '0;
  logic [31:0]         m_key = '0;
  logic [1:0]          m_key_idx = '0;
  logic                m_closed = 1'b0;
  logic [MAXLEN_W-1:0] m_max_payload = MAX_PAYLOAD_RST;

  frame_event_t pending_events[$];
  frame_event_t want;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           bytes_sent = 0;
  int           burst_left = 0;
  bit           sender_gaps = 1'b1;
  int           hold_cycles = 0;
  int           pattern_left = 0;
  stall_pattern_t stall_pattern = STALL_NONE;

  function automatic void expect_event(input logic [1:0] kind, input logic [7:0] data,
                                       input logic last);
    frame_event_t ev;
    ev.kind = kind;
    ev.data = data;
    ev.last = last;
    pending_events.insert(pending_events.size(), ev);
  endfunction

  // length known: decide ping / drop / oversize, then go to key, payload or next header
  function automatic void length_complete();
    if (m_opcode == OP_PING) begin
      expect_event(KIND_PING, 8'h00, 1'b0);
    end else if (m_opcode != OP_TEXT) begin
      expect_event(KIND_DROP, 8'h00, 1'b0);
    end else if (m_remaining > 64'(m_max_payload)) begin
      m_opcode = OP_CONT;
      expect_event(KIND_DROP, 8'h00, 1'b0);
    end
    if (m_mask_on) begin
      m_key_idx = '0;
      m_phase = P_KEY;
    end else begin
      m_phase = (m_remaining != 0) ? P_BODY : P_HDR0;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [6:0] len7;
    logic [7:0] kb;
    if (m_closed) return;
    case (m_phase)
      P_HDR0: begin
        m_opcode = b[3:0];
        m_phase = P_HDR1;
      end
      P_HDR1: begin
        m_mask_on = b[7];
        len7 = b[6:0];
        m_key = '0;
        m_key_idx = '0;
        if (m_opcode == OP_CLOSE) begin
          m_closed = 1'b1;
          m_phase = P_HDR0;
          expect_event(KIND_CLOSE, 8'h00, 1'b0);
        end else begin
          m_remaining = '0;
          if (len7 == LEN_EXT16) begin
            m_ext_left = 3'd1;
            m_phase = P_EXT;
          end else if (len7 == LEN_EXT64) begin
            m_ext_left = 3'd7;
            m_phase = P_EXT;
          end else begin
            m_remaining = 64'(len7);
            length_complete();
          end
        end
      end
      P_EXT: begin
        m_remaining = {m_remaining[LEN_W-9:0], b};
        if (m_ext_left == 0) length_complete();
        else m_ext_left--;
      end
      P_KEY: begin
        m_key[(3 - m_key_idx) * 8 +: 8] = b;
        if (m_key_idx == 2'd3) begin
          m_key_idx = '0;
          m_phase = (m_remaining != 0) ? P_BODY : P_HDR0;
        end else begin
          m_key_idx++;
        end
      end
      P_BODY: begin
        kb = m_key[(3 - m_key_idx) * 8 +: 8];
        m_key_idx++;
        m_remaining--;
        if (m_remaining == 0) m_phase = P_HDR0;
        if (m_opcode == OP_TEXT) expect_event(KIND_DATA, b ^ kb, m_remaining == 0);
      end
      default: m_phase = P_HDR0;
    endcase
  endfunction

  // called right after a rising edge; returns at the edge that took the byte
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_frame(input logic [3:0] flags, input logic [3:0] opcode,
                            input bit masked, input logic [63:0] len,
                            input len_form_t form, input logic [31:0] key);
    send_byte({flags, opcode});
    case (form)
      FORM_7: send_byte({masked, len[6:0]});
      FORM_16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[i * 8 +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) send_byte(key[i * 8 +: 8]);
    for (int n = 0; n < int'(len); n++) send_byte(8'($urandom));
  endtask

  // lower valid, wait out every event plus pipeline slack for result-free bytes
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_payload(input logic [MAXLEN_W-1:0] value);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_max_payload <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_max_payload = value;
  endtask

  task automatic test_text_frames();
    // unmasked, one byte at the top of the range
    send_byte({4'h8, OP_TEXT});
    send_byte({1'b0, 7'd1});
    send_byte(8'hFF);
    // masked, FIN clear
    send_byte({4'h0, OP_TEXT});
    send_byte({1'b1, 7'd2});
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hA5);
    send_byte(8'h3C);
    send_byte(8'h00);
    send_byte(8'h5A);
    // empty text frame gives nothing
    send_byte({4'h8, OP_TEXT});
    send_byte({1'b0, 7'd0});
  endtask

  task automatic test_control_and_drops();
    // ping with 16-bit length, payload skipped
    send_byte({4'h8, OP_PING});
    send_byte({1'b0, LEN_EXT16});
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h77);
    // continuation is dropped
    send_byte({4'hF, OP_CONT});
    send_byte({1'b0, 7'd0});
  endtask

  task automatic test_oversize();
    set_max_payload('0);
    send_byte({4'h8, OP_TEXT});
    send_byte({1'b0, 7'd1});
    send_byte(8'h33);
  endtask

  task automatic send_random_frame();
    logic [3:0]  opcode;
    logic [63:0] len;
    len_form_t   form;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      opcode = OP_TEXT;
    end else if (pick < 7) begin
      opcode = OP_PING;
    end else begin
      do opcode = 4'($urandom_range(0, 15));
      while (opcode == OP_TEXT || opcode == OP_CLOSE || opcode == OP_PING);
    end
    pick = $urandom_range(0, 19);
    if (pick < 14) len = 64'($urandom_range(0, 12));
    else if (pick < 19) len = 64'($urandom_range(13, 60));
    else len = 64'($urandom_range(100, 300));
    pick = $urandom_range(0, 9);
    if (len < 126) form = (pick < 7) ? FORM_7 : (pick < 9) ? FORM_16 : FORM_64;
    else form = (pick < 7) ? FORM_16 : FORM_64;
    send_frame(4'($urandom_range(0, 15)), opcode, bit'($urandom_range(0, 1)), len, form,
               $urandom);
  endtask

  task automatic test_random_traffic();
    int start;
    logic [MAXLEN_W-1:0] limit;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      case ($urandom_range(0, 5))
        0: limit = '0;
        1: limit = MAXLEN_W'($urandom_range(1, 16));
        2: limit = MAXLEN_W'($urandom_range(17, 300));
        3: limit = MAX_PAYLOAD_RST;
        4: limit = '1;
        default: limit = MAXLEN_W'($urandom_range(0, 2 ** MAXLEN_W - 1));
      endcase
      set_max_payload(limit);
      sender_gaps = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(3, 8)) send_random_frame();
    end
  endtask

  // receiver holds off long enough for the block to fill and stall the sender
  task automatic test_backpressure();
    set_max_payload('1);
    sender_gaps = 1'b0;
    hold_cycles = 400;
    send_frame(4'h8, OP_TEXT, 1'b1, 64'd200, FORM_16, $urandom);
    sender_gaps = 1'b1;
  endtask

  // close event, then everything is ignored
  task automatic test_close();
    send_frame(4'h8, OP_CLOSE, 1'b1, 64'd5, FORM_7, $urandom);
    repeat (12) send_byte(8'($urandom));
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      if (pattern_left == 0) begin
        stall_pattern = stall_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(32, 256);
      end
      pattern_left--;
      case (stall_pattern)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (pattern_left % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event: kind %0d data %02h last %0b", out_kind, out_data, out_last);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind mismatch: expected %0d, got %0d", want.kind, out_kind);
          mismatch_count++;
        end
        if (out_data !== want.data) begin
          $error("out_data mismatch: expected %02h, got %02h", want.data, out_data);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last mismatch: expected %0b, got %0b", want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("websocket_frame_deframer_test: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_text_frames();
    test_control_and_drops();
    test_oversize();
    test_random_traffic();
    test_backpressure();
    test_close();
    drain_pipeline();
    if (pending_events.size() != 0) begin
      $error("%0d expected events never arrived", pending_events.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("websocket_frame_deframer_test: PASS");
    end else begin
      $display("websocket_frame_deframer_test: FAIL");
    end
    $finish;
  end

endmodule
